// ===== sv/irts_pkg.sv =====
// Package with phase, command and flag codes and the structs shared by the sequencer files.
`timescale 1ns / 1ps

package irts_pkg;

   // Transaction phases
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_WAIT_STOP = 4'd1,
      PH_TX_START  = 4'd2,
      PH_CONFIRM   = 4'd3,
      PH_REG       = 4'd4,
      PH_DATA      = 4'd5,
      PH_RX_START  = 4'd6,
      PH_RX_DATA   = 4'd7,
      PH_DONE_OK   = 4'd8,
      PH_DONE_NACK = 4'd9
   } phase_type;

   // Command codes carried by each request
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_ABORT = 2'd3
   } mode_type;

   // Engine flag clear mask bits
   localparam logic [2:0] CLR_TX   = 3'b001;
   localparam logic [2:0] CLR_RX   = 3'b010;
   localparam logic [2:0] CLR_NACK = 3'b100;
   localparam logic [2:0] CLR_NONE = 3'b000;

   // Sequencer state held between transfers
   typedef struct packed {
      phase_type   phase;
      logic [6:0]  dev_id;
      logic [7:0]  reg_index;
      logic        is_read;
      logic [7:0]  data_byte;
   } state_type;

   // One request: command plus engine flag snapshot
   typedef struct packed {
      mode_type    mode;
      logic [6:0]  dev_id;
      logic [7:0]  reg_index;
      logic [7:0]  write_data;
      logic        stop_pending;
      logic        start_pending;
      logic        tx_ready;
      logic        rx_ready;
      logic        nack_seen;
      logic [7:0]  rx_byte;
   } req_type;

   // One response: status, phase and engine strobes
   typedef struct packed {
      logic        command_status;
      logic [3:0]  phase;
      logic [7:0]  read_data;
      logic        issue_start;
      logic        issue_stop;
      logic        set_receive;
      logic        set_transmit;
      logic        load_tx;
      logic [7:0]  tx_byte;
      logic [6:0]  target_address;
      logic [2:0]  clear_flags;
   } rsp_type;

endpackage

// ===== sv/irts_if.sv =====
// Valid/ready channel interfaces for sequencer requests and responses.
`timescale 1ns / 1ps

interface irts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [6:0]  dev_id;
   logic [7:0]  reg_index;
   logic [7:0]  write_data;
   logic        stop_pending;
   logic        start_pending;
   logic        tx_ready;
   logic        rx_ready;
   logic        nack_seen;
   logic [7:0]  rx_byte;

   modport source (
      output valid, mode, dev_id, reg_index, write_data, stop_pending,
             start_pending, tx_ready, rx_ready, nack_seen, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, mode, dev_id, reg_index, write_data, stop_pending,
             start_pending, tx_ready, rx_ready, nack_seen, rx_byte,
      output ready
   );
endinterface

interface irts_rsp_if;
   logic        valid;
   logic        ready;
   logic        command_status;
   logic [3:0]  phase;
   logic [7:0]  read_data;
   logic        issue_start;
   logic        issue_stop;
   logic        set_receive;
   logic        set_transmit;
   logic        load_tx;
   logic [7:0]  tx_byte;
   logic [6:0]  target_address;
   logic [2:0]  clear_flags;

   modport source (
      output valid, command_status, phase, read_data, issue_start, issue_stop,
             set_receive, set_transmit, load_tx, tx_byte, target_address,
             clear_flags,
      input  ready
   );
   modport sink (
      input  valid, command_status, phase, read_data, issue_start, issue_stop,
             set_receive, set_transmit, load_tx, tx_byte, target_address,
             clear_flags,
      output ready
   );
endinterface

// ===== sv/irts_step.sv =====
// Single phase step: next sequencer state and engine strobes for one request.
`timescale 1ns / 1ps

module irts_step (
   input  irts_pkg::state_type state_ff,
   input  irts_pkg::req_type   req,
   output irts_pkg::state_type state_in,
   output irts_pkg::rsp_type   rsp
);
   import irts_pkg::*;

   always_comb begin
      logic active;
      logic nack_err;

      active   = state_ff.phase inside {[PH_WAIT_STOP:PH_RX_DATA]};
      nack_err = 1'b0;
      state_in = state_ff;
      rsp      = '0;

      case (req.mode)
         MODE_WRITE, MODE_READ: begin
            // start refused while a transaction is running
            if (active) begin
               rsp.command_status = 1'b1;
            end else begin
               state_in.dev_id    = req.dev_id;
               state_in.reg_index = req.reg_index;
               state_in.is_read   = (req.mode == MODE_READ);
               state_in.data_byte = (req.mode == MODE_READ) ? 8'd0 : req.write_data;
               state_in.phase     = PH_WAIT_STOP;
            end
         end
         MODE_ABORT: begin
            if (active) begin
               rsp.issue_stop = 1'b1;
               state_in.phase = PH_IDLE;
            end
         end
         default: begin
            // poll tick: at most one phase step
            case (state_ff.phase)
               PH_WAIT_STOP: begin
                  if (!req.stop_pending) begin
                     rsp.clear_flags  = CLR_TX | CLR_RX | CLR_NACK;
                     rsp.set_transmit = 1'b1;
                     rsp.issue_start  = 1'b1;
                     state_in.phase   = PH_TX_START;
                  end
               end
               PH_TX_START: begin
                  if (req.tx_ready) begin
                     rsp.load_tx     = 1'b1;
                     rsp.tx_byte     = state_ff.reg_index;
                     rsp.clear_flags = CLR_TX;
                     state_in.phase  = PH_CONFIRM;
                  end
               end
               PH_CONFIRM: begin
                  if (!req.start_pending) begin
                     if (req.nack_seen) nack_err = 1'b1;
                     else               state_in.phase = PH_REG;
                  end
               end
               PH_REG: begin
                  if (req.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (req.tx_ready) begin
                     if (state_ff.is_read) begin
                        rsp.set_receive = 1'b1;
                        rsp.issue_start = 1'b1;
                        state_in.phase  = PH_RX_START;
                     end else begin
                        rsp.load_tx     = 1'b1;
                        rsp.tx_byte     = state_ff.data_byte;
                        rsp.clear_flags = CLR_TX;
                        state_in.phase  = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  if (req.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (req.tx_ready) begin
                     rsp.clear_flags = CLR_TX;
                     rsp.issue_stop  = 1'b1;
                     state_in.phase  = PH_DONE_OK;
                  end
               end
               PH_RX_START: begin
                  if (req.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (!req.start_pending) begin
                     rsp.issue_stop = 1'b1;
                     state_in.phase = PH_RX_DATA;
                  end
               end
               PH_RX_DATA: begin
                  if (req.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (req.rx_ready) begin
                     state_in.data_byte = req.rx_byte;
                     rsp.clear_flags    = CLR_RX;
                     state_in.phase     = PH_DONE_OK;
                  end
               end
               default: begin
                  // idle and done phases hold
               end
            endcase

            // NACK ends the transaction with a stop
            if (nack_err) begin
               rsp.issue_start  = 1'b0;
               rsp.set_receive  = 1'b0;
               rsp.load_tx      = 1'b0;
               rsp.tx_byte      = 8'd0;
               rsp.issue_stop   = 1'b1;
               rsp.clear_flags  = CLR_NACK;
               state_in.phase   = PH_DONE_NACK;
            end
         end
      endcase

      // fields that follow the new state
      rsp.phase          = state_in.phase;
      rsp.target_address = state_in.dev_id;
      rsp.read_data      = (state_in.phase == PH_DONE_OK && state_in.is_read)
                           ? state_in.data_byte : 8'd0;
   end

endmodule

// ===== sv/i2c_register_transaction_sequencer_unit.sv =====
// Top level of the I2C register transaction sequencer.
// Each request transfer (a start write, start read, abort or a poll tick with
// the engine's flag snapshot) is turned into one response transfer carrying
// the command status, the new phase and the strobes for the I2C master
// engine. A request is taken every clock: the phase step is combinational
// logic on the request and the held state, and its response is registered
// in the output register on the request transfer. The output register lets
// the next request in while the current response is being taken, so
// sustained rate is one item per clock; the request side stalls only while
// a response is held and the sink is not ready.
`timescale 1ns / 1ps

module i2c_register_transaction_sequencer_unit (
   input logic       clock,
   input logic       reset,
   irts_req_if.sink  req_if,
   irts_rsp_if.source rsp_if
);
   import irts_pkg::*;

   state_type state_ff;
   state_type state_in;
   req_type   req;
   rsp_type   rsp_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      req_take;

   // gather the request payload
   always_comb begin
      req.mode          = mode_type'(req_if.mode);
      req.dev_id        = req_if.dev_id;
      req.reg_index     = req_if.reg_index;
      req.write_data    = req_if.write_data;
      req.stop_pending  = req_if.stop_pending;
      req.start_pending = req_if.start_pending;
      req.tx_ready      = req_if.tx_ready;
      req.rx_ready      = req_if.rx_ready;
      req.nack_seen     = req_if.nack_seen;
      req.rx_byte       = req_if.rx_byte;
   end

   irts_step u_step (
      .state_ff (state_ff),
      .req      (req),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   // accept while the output register is free or being drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_IDLE;
         state_ff.dev_id    <= 7'd0;
         state_ff.reg_index <= 8'd0;
         state_ff.is_read   <= 1'b0;
         state_ff.data_byte <= 8'd0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   // drive the response channel
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.command_status = rsp_ff.command_status;
   assign rsp_if.phase          = rsp_ff.phase;
   assign rsp_if.read_data      = rsp_ff.read_data;
   assign rsp_if.issue_start    = rsp_ff.issue_start;
   assign rsp_if.issue_stop     = rsp_ff.issue_stop;
   assign rsp_if.set_receive    = rsp_ff.set_receive;
   assign rsp_if.set_transmit   = rsp_ff.set_transmit;
   assign rsp_if.load_tx        = rsp_ff.load_tx;
   assign rsp_if.tx_byte        = rsp_ff.tx_byte;
   assign rsp_if.target_address = rsp_ff.target_address;
   assign rsp_if.clear_flags    = rsp_ff.clear_flags;

endmodule

// ===== test/tb_i2c_register_transaction_sequencer_unit.sv =====
// Testbench for the I2C register transaction sequencer: directed and random transfers, scoreboard.
`timescale 1ns / 1ps

module tb_i2c_register_transaction_sequencer_unit;
   import irts_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 100;

   logic clock;
   logic reset;

   irts_req_if req_ch ();
   irts_rsp_if rsp_ch ();

   i2c_register_transaction_sequencer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Mirror of the sequencer state
   phase_type  seq_phase = PH_IDLE;
   logic [6:0] seq_dev = '0;
   logic [7:0] seq_reg = '0;
   logic       seq_is_read = 1'b0;
   logic [7:0] seq_byte = '0;

   rsp_type    expected_rsp_q[$];
   int         error_count;
   int         cycle_count;
   int         send_idle_pct;
   int         recv_stall_pct;

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_i2c_register_transaction_sequencer_unit: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] g);
      if (g !== e)
         report_mismatch($sformatf("%s expected %0h got %0h", name, e, g));
   endtask

   // One phase step of the sequencer on an accepted request
   task automatic step_sequencer(input req_type r, output rsp_type e);
      logic active;
      logic nack_err;
      e = '0;
      nack_err = 1'b0;
      active = (seq_phase >= PH_WAIT_STOP) && (seq_phase <= PH_RX_DATA);
      case (r.mode)
         MODE_WRITE, MODE_READ: begin
            if (active) begin
               e.command_status = 1'b1;
            end else begin
               seq_dev     = r.dev_id;
               seq_reg     = r.reg_index;
               seq_is_read = (r.mode == MODE_READ);
               seq_byte    = (r.mode == MODE_READ) ? 8'd0 : r.write_data;
               seq_phase   = PH_WAIT_STOP;
            end
         end
         MODE_ABORT: begin
            if (active) begin
               e.issue_stop = 1'b1;
               seq_phase = PH_IDLE;
            end
         end
         default: begin
            case (seq_phase)
               PH_WAIT_STOP: begin
                  if (!r.stop_pending) begin
                     e.clear_flags  = CLR_TX | CLR_RX | CLR_NACK;
                     e.set_transmit = 1'b1;
                     e.issue_start  = 1'b1;
                     seq_phase = PH_TX_START;
                  end
               end
               PH_TX_START: begin
                  if (r.tx_ready) begin
                     e.load_tx     = 1'b1;
                     e.tx_byte     = seq_reg;
                     e.clear_flags = CLR_TX;
                     seq_phase = PH_CONFIRM;
                  end
               end
               // nack only counts once the start has gone out
               PH_CONFIRM: begin
                  if (!r.start_pending) begin
                     if (r.nack_seen) nack_err = 1'b1;
                     else seq_phase = PH_REG;
                  end
               end
               PH_REG: begin
                  if (r.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (r.tx_ready) begin
                     if (seq_is_read) begin
                        e.set_receive = 1'b1;
                        e.issue_start = 1'b1;
                        seq_phase = PH_RX_START;
                     end else begin
                        e.load_tx     = 1'b1;
                        e.tx_byte     = seq_byte;
                        e.clear_flags = CLR_TX;
                        seq_phase = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  if (r.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (r.tx_ready) begin
                     e.clear_flags = CLR_TX;
                     e.issue_stop  = 1'b1;
                     seq_phase = PH_DONE_OK;
                  end
               end
               PH_RX_START: begin
                  if (r.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (!r.start_pending) begin
                     e.issue_stop = 1'b1;
                     seq_phase = PH_RX_DATA;
                  end
               end
               PH_RX_DATA: begin
                  if (r.nack_seen) begin
                     nack_err = 1'b1;
                  end else if (r.rx_ready) begin
                     seq_byte      = r.rx_byte;
                     e.clear_flags = CLR_RX;
                     seq_phase = PH_DONE_OK;
                  end
               end
               default: ;
            endcase
            if (nack_err) begin
               e.issue_stop  = 1'b1;
               e.clear_flags = CLR_NACK;
               seq_phase = PH_DONE_NACK;
            end
         end
      endcase
      e.phase          = seq_phase;
      e.read_data      = (seq_phase == PH_DONE_OK && seq_is_read) ? seq_byte : 8'd0;
      e.target_address = seq_dev;
   endtask

   // Predict on each request transfer, then check each response transfer
   always @(posedge clock) begin : scoreboard
      req_type taken;
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            taken = {req_ch.mode, req_ch.dev_id, req_ch.reg_index, req_ch.write_data,
                     req_ch.stop_pending, req_ch.start_pending, req_ch.tx_ready,
                     req_ch.rx_ready, req_ch.nack_seen, req_ch.rx_byte};
            step_sequencer(taken, want);
            expected_rsp_q.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.command_status, rsp_ch.phase, rsp_ch.read_data, rsp_ch.issue_start,
                   rsp_ch.issue_stop, rsp_ch.set_receive, rsp_ch.set_transmit,
                   rsp_ch.load_tx, rsp_ch.tx_byte, rsp_ch.target_address,
                   rsp_ch.clear_flags};
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response transfer with nothing expected");
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("command_status", 8'(want.command_status),
                           8'(got.command_status));
               check_field("phase", 8'(want.phase), 8'(got.phase));
               check_field("read_data", want.read_data, got.read_data);
               check_field("issue_start", 8'(want.issue_start), 8'(got.issue_start));
               check_field("issue_stop", 8'(want.issue_stop), 8'(got.issue_stop));
               check_field("set_receive", 8'(want.set_receive), 8'(got.set_receive));
               check_field("set_transmit", 8'(want.set_transmit), 8'(got.set_transmit));
               check_field("load_tx", 8'(want.load_tx), 8'(got.load_tx));
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("target_address", 8'(want.target_address),
                           8'(got.target_address));
               check_field("clear_flags", 8'(want.clear_flags), 8'(got.clear_flags));
            end
         end
      end
   end

   // Response sink back-pressure
   always @(posedge clock)
      rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

   // Send one request, with random idle cycles ahead of it
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= r.mode;
      req_ch.dev_id        <= r.dev_id;
      req_ch.reg_index     <= r.reg_index;
      req_ch.write_data    <= r.write_data;
      req_ch.stop_pending  <= r.stop_pending;
      req_ch.start_pending <= r.start_pending;
      req_ch.tx_ready      <= r.tx_ready;
      req_ch.rx_ready      <= r.rx_ready;
      req_ch.nack_seen     <= r.nack_seen;
      req_ch.rx_byte       <= r.rx_byte;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Poll tick with the given flags; address fields are don't-care
   function automatic req_type tick_item(input logic stp, input logic stt, input logic txr,
                                         input logic rxr, input logic nack,
                                         input logic [7:0] rxb);
      req_type r;
      r.mode          = MODE_TICK;
      r.dev_id        = 7'($urandom_range(127));
      r.reg_index     = 8'($urandom_range(255));
      r.write_data    = 8'($urandom_range(255));
      r.stop_pending  = stp;
      r.start_pending = stt;
      r.tx_ready      = txr;
      r.rx_ready      = rxr;
      r.nack_seen     = nack;
      r.rx_byte       = rxb;
      return r;
   endfunction

   // Command with random engine flags
   function automatic req_type command_item(input mode_type m, input logic [6:0] dev,
                                            input logic [7:0] ra, input logic [7:0] wdat);
      req_type r;
      r = tick_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)),
                    8'($urandom_range(255)));
      r.mode       = m;
      r.dev_id     = dev;
      r.reg_index  = ra;
      r.write_data = wdat;
      return r;
   endfunction

   // Mostly flag snapshots biased to make progress, some starts, rare aborts, some noise
   function automatic req_type random_item();
      logic [63:0] raw;
      int          sel;
      sel = $urandom_range(99);
      raw = {$urandom, $urandom};
      if (sel < 15)
         return req_type'(raw[$bits(req_type)-1:0]);
      else if (sel < 22)
         return command_item(MODE_WRITE, raw[6:0], raw[15:8], raw[23:16]);
      else if (sel < 29)
         return command_item(MODE_READ, raw[6:0], raw[15:8], raw[23:16]);
      else if (sel < 31)
         return command_item(MODE_ABORT, raw[6:0], raw[15:8], raw[23:16]);
      return tick_item($urandom_range(99) < 25, $urandom_range(99) < 25,
                       $urandom_range(99) >= 30, $urandom_range(99) >= 35,
                       $urandom_range(99) < 8, raw[31:24]);
   endfunction

   task automatic run_random(input int n);
      repeat (n) send_request(random_item());
   endtask

   // Full write and read, refusal, aborts, nack after confirm, ticks in idle and done
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(tick_item(1, 1, 1, 1, 1, 8'hFF));
      send_request(command_item(MODE_ABORT, 7'h7F, 8'hFF, 8'hFF));
      send_request(command_item(MODE_WRITE, 7'h7F, 8'hFF, 8'h00));
      send_request(command_item(MODE_READ, 7'h00, 8'h00, 8'hFF));
      send_request(tick_item(1, 0, 0, 0, 0, 8'h00));
      send_request(tick_item(0, 1, 0, 1, 1, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 1, 0, 0, 1, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 1, 1, 0, 8'hA5));
      // read with all-ones captured byte
      send_request(command_item(MODE_READ, 7'h00, 8'h00, 8'hFF));
      send_request(tick_item(0, 0, 0, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 0, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 0, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 0, 1, 0, 8'hFF));
      send_request(command_item(MODE_ABORT, 7'h00, 8'h00, 8'h00));
      // nack once start is clear
      send_request(command_item(MODE_WRITE, 7'h55, 8'hAA, 8'hFF));
      send_request(tick_item(0, 0, 0, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 1, 0, 0, 8'h00));
      send_request(tick_item(0, 0, 0, 0, 1, 8'h00));
      // abort mid transaction
      send_request(command_item(MODE_READ, 7'h2A, 8'h55, 8'h00));
      send_request(command_item(MODE_ABORT, 7'h00, 8'h00, 8'h00));
   endtask

   task automatic test_random_no_idling();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(240);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 67;
      recv_stall_pct = 0;
      run_random(240);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      recv_stall_pct = 67;
      run_random(240);
   endtask

   task automatic test_both_idling();
      send_idle_pct = 20;
      recv_stall_pct = 20;
      run_random(240);
   endtask

   initial begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_TICK;
      req_ch.dev_id        = '0;
      req_ch.reg_index     = '0;
      req_ch.write_data    = '0;
      req_ch.stop_pending  = 1'b0;
      req_ch.start_pending = 1'b0;
      req_ch.tx_ready      = 1'b0;
      req_ch.rx_ready      = 1'b0;
      req_ch.nack_seen     = 1'b0;
      req_ch.rx_byte       = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_no_idling();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idling();
      req_ch.valid <= 1'b0;

      // drain, then watch for any stray transfer
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      if (error_count == 0)
         $display("tb_i2c_register_transaction_sequencer_unit: PASS");
      else
         $display("tb_i2c_register_transaction_sequencer_unit: FAIL");
      $finish;
   end

endmodule
